// ===== hw/rtl/ehash_pkg.sv =====
// shared types, constants and codes for the extendible hash table
package ehash_pkg;

    localparam int MAX_DEPTH     = 8;
    localparam int SLOTS         = 4;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int DIR_W         = MAX_DEPTH;
    localparam int DIR_SIZE      = 1 << MAX_DEPTH;
    localparam int GD_W          = $clog2(MAX_DEPTH + 1);
    localparam int LD_W          = GD_W;
    localparam int FILL_W        = $clog2(SLOTS + 1);
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int CNT_W         = DIR_W + 1;
    localparam int CAP_W         = 3;
    localparam logic [CAP_W-1:0] CAP_RESET = 3'd3;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOTFOUND = 2'd1,
        STAT_FULL     = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIR_RD,
        S_META_RD,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_DEL_META,
        S_DBL_RD,
        S_DBL_WR,
        S_SP_RD,
        S_SP_WR,
        S_SP_MB,
        S_SP_MN,
        S_SP_DRD,
        S_SP_DWR,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [DIR_W-1:0]   bucket_index;
        logic [GD_W-1:0]    depth_now;
    } result_t;

endpackage

// ===== hw/rtl/ehash_core.sv =====
// command sequencer with directory, bucket and slot memories
module ehash_core
    import ehash_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CAP_W-1:0]     capacity,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_command,
    input  logic [KEY_WIDTH-1:0] in_key,
    output logic                 out_valid,
    input  logic                 out_ready,
    output result_t              out_result
);

    localparam int META_W = LD_W + FILL_W;
    localparam int SADDR_W = DIR_W + SLOT_W;

    logic [DIR_W-1:0]     dir_mem  [DIR_SIZE];
    logic [META_W-1:0]    meta_mem [DIR_SIZE];
    logic [KEY_WIDTH-1:0] slot_mem [DIR_SIZE*SLOTS];

    state_t               state_reg, state_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [GD_W-1:0]      gd_reg, gd_next;
    logic [CNT_W-1:0]     biu_reg, biu_next;
    logic [DIR_W-1:0]     idx_reg, idx_next;
    logic [DIR_W-1:0]     b_reg, b_next;
    logic [LD_W-1:0]      ld_reg, ld_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [FILL_W-1:0]    si_reg, si_next;
    logic [FILL_W-1:0]    nk_reg, nk_next;
    logic [FILL_W-1:0]    nn_reg, nn_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 dir0_w_reg, meta0_w_reg;
    logic                 out_valid_reg, out_valid_next;
    result_t              res_reg, res_next;
    status_t              stat_reg, stat_next;
    logic [DIR_W-1:0]     where_reg, where_next;

    // memory ports
    logic                 dir_we, meta_we, slot_we;
    logic [DIR_W-1:0]     dir_waddr, dir_raddr, dir_wdata;
    logic [DIR_W-1:0]     meta_waddr, meta_raddr;
    logic [META_W-1:0]    meta_wdata;
    logic [SADDR_W-1:0]   slot_waddr, slot_raddr;
    logic [KEY_WIDTH-1:0] slot_wdata;
    logic [DIR_W-1:0]     dir_q_reg;
    logic [META_W-1:0]    meta_q_reg;
    logic [KEY_WIDTH-1:0] slot_q_reg;
    logic                 dir_z_reg, meta_z_reg;

    logic [DIR_W-1:0]     dir_q;
    logic [LD_W-1:0]      meta_ld;
    logic [FILL_W-1:0]    meta_fill;
    logic [FILL_W-1:0]    cap_now;
    logic [CNT_W-1:0]     dir_span;
    logic [DIR_W-1:0]     key_idx;
    logic [CNT_W-1:0]     dbl_dst;

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        dir_q_reg  <= dir_mem[dir_raddr];
        meta_q_reg <= meta_mem[meta_raddr];
        slot_q_reg <= slot_mem[slot_raddr];
    end

    // entry zero of directory and bucket table reads as zero until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir0_w_reg  <= 1'b0;
            meta0_w_reg <= 1'b0;
            dir_z_reg   <= 1'b0;
            meta_z_reg  <= 1'b0;
        end
        else
        begin
            if (dir_we && dir_waddr == '0)
            begin
                dir0_w_reg <= 1'b1;
            end
            if (meta_we && meta_waddr == '0)
            begin
                meta0_w_reg <= 1'b1;
            end
            dir_z_reg  <= (dir_raddr == '0) && !dir0_w_reg;
            meta_z_reg <= (meta_raddr == '0) && !meta0_w_reg;
        end
    end

    assign dir_q     = dir_z_reg ? '0 : dir_q_reg;
    assign meta_ld   = meta_z_reg ? '0 : meta_q_reg[META_W-1:FILL_W];
    assign meta_fill = meta_z_reg ? '0 : meta_q_reg[FILL_W-1:0];
    assign cap_now   = (capacity == '0) ? FILL_W'(1) :
                       (capacity > CAP_W'(SLOTS)) ? FILL_W'(SLOTS) : FILL_W'(capacity);
    assign dir_span  = CNT_W'(1) << gd_reg;
    assign key_idx   = key_reg[DIR_W-1:0] & DIR_W'(dir_span - CNT_W'(1));
    assign dbl_dst   = cnt_reg + dir_span;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gd_reg        <= '0;
            biu_reg       <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gd_reg        <= gd_next;
            biu_reg       <= biu_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        idx_reg   <= idx_next;
        b_reg     <= b_next;
        ld_reg    <= ld_next;
        fill_reg  <= fill_next;
        si_reg    <= si_next;
        nk_reg    <= nk_next;
        nn_reg    <= nn_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
        where_reg <= where_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command inside {CMD_INSERT, CMD_SEARCH, CMD_DELETE})
                    begin
                        state_next = S_DIR_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DIR_RD:   state_next = S_META_RD;
            S_META_RD:  state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    if (meta_fill < cap_now || meta_ld >= LD_W'(MAX_DEPTH))
                    begin
                        state_next = S_DONE;
                    end
                    else if (meta_ld == gd_reg)
                    begin
                        state_next = S_DBL_RD;
                    end
                    else
                    begin
                        state_next = S_SP_RD;
                    end
                end
                else if (meta_fill == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:  state_next = S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                if (slot_q_reg == key_reg)
                begin
                    state_next = (cmd_reg == CMD_DELETE) ? S_DEL_RD : S_DONE;
                end
                else if (si_reg + FILL_W'(1) == fill_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_DEL_RD:   state_next = (si_reg + FILL_W'(1) >= fill_reg) ? S_DEL_META : S_DEL_WR;
            S_DEL_WR:   state_next = S_DEL_RD;
            S_DEL_META: state_next = S_DONE;
            S_DBL_RD:   state_next = S_DBL_WR;
            S_DBL_WR:   state_next = (cnt_reg + CNT_W'(1) == dir_span) ? S_SP_RD : S_DBL_RD;
            S_SP_RD:    state_next = (si_reg == fill_reg) ? S_SP_MB : S_SP_WR;
            S_SP_WR:    state_next = S_SP_RD;
            S_SP_MB:    state_next = S_SP_MN;
            S_SP_MN:    state_next = S_SP_DRD;
            S_SP_DRD:   state_next = (cnt_reg == dir_span) ? S_DIR_RD : S_SP_DWR;
            S_SP_DWR:   state_next = S_SP_DRD;
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        gd_next    = gd_reg;
        biu_next   = biu_reg;
        idx_next   = idx_reg;
        b_next     = b_reg;
        ld_next    = ld_reg;
        fill_next  = fill_reg;
        si_next    = si_reg;
        nk_next    = nk_reg;
        nn_next    = nn_reg;
        cnt_next   = cnt_reg;
        stat_next  = stat_reg;
        where_next = where_reg;
        res_next   = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready   = 1'b0;
        dir_we     = 1'b0;
        dir_waddr  = cnt_reg[DIR_W-1:0];
        dir_wdata  = biu_reg[DIR_W-1:0];
        dir_raddr  = cnt_reg[DIR_W-1:0];
        meta_we    = 1'b0;
        meta_waddr = b_reg;
        meta_wdata = {ld_reg, fill_reg};
        meta_raddr = b_reg;
        slot_we    = 1'b0;
        slot_waddr = {b_reg, si_reg[SLOT_W-1:0]};
        slot_wdata = key_reg;
        slot_raddr = {b_reg, si_reg[SLOT_W-1:0]};
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd_next   = in_command;
                key_next   = in_key;
                stat_next  = STAT_NOTFOUND;
                where_next = '0;
            end
            S_DIR_RD:
            begin
                idx_next  = key_idx;
                dir_raddr = key_idx;
            end
            S_META_RD:
            begin
                b_next     = dir_q;
                meta_raddr = dir_q;
            end
            S_DECIDE:
            begin
                ld_next   = meta_ld;
                fill_next = meta_fill;
                si_next   = '0;
                nk_next   = '0;
                nn_next   = '0;
                cnt_next  = '0;
                if (cmd_reg == CMD_INSERT)
                begin
                    if (meta_fill < cap_now)
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = {b_reg, meta_fill[SLOT_W-1:0]};
                        meta_we    = 1'b1;
                        meta_wdata = {meta_ld, meta_fill + FILL_W'(1)};
                        stat_next  = STAT_OK;
                        where_next = idx_reg;
                    end
                    else if (meta_ld >= LD_W'(MAX_DEPTH))
                    begin
                        stat_next = STAT_FULL;
                    end
                end
            end
            S_SCAN_CMP:
            begin
                if (slot_q_reg == key_reg)
                begin
                    stat_next  = STAT_OK;
                    where_next = idx_reg;
                end
                else
                begin
                    si_next = si_reg + FILL_W'(1);
                end
            end
            S_DEL_RD:
            begin
                slot_raddr = {b_reg, SLOT_W'(si_reg + FILL_W'(1))};
            end
            S_DEL_WR:
            begin
                // move the following key down over the removed one
                slot_we    = 1'b1;
                slot_wdata = slot_q_reg;
                si_next    = si_reg + FILL_W'(1);
            end
            S_DEL_META:
            begin
                meta_we    = 1'b1;
                meta_wdata = {ld_reg, fill_reg - FILL_W'(1)};
            end
            S_DBL_WR:
            begin
                // upper half of directory copies lower half
                dir_we    = 1'b1;
                dir_waddr = dbl_dst[DIR_W-1:0];
                dir_wdata = dir_q;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg + CNT_W'(1) == dir_span)
                begin
                    gd_next = gd_reg + GD_W'(1);
                end
            end
            S_SP_WR:
            begin
                slot_we    = 1'b1;
                slot_wdata = slot_q_reg;
                si_next    = si_reg + FILL_W'(1);
                if (slot_q_reg[ld_reg])
                begin
                    slot_waddr = {biu_reg[DIR_W-1:0], nn_reg[SLOT_W-1:0]};
                    nn_next    = nn_reg + FILL_W'(1);
                end
                else
                begin
                    slot_waddr = {b_reg, nk_reg[SLOT_W-1:0]};
                    nk_next    = nk_reg + FILL_W'(1);
                end
            end
            S_SP_MB:
            begin
                meta_we    = 1'b1;
                meta_wdata = {ld_reg + LD_W'(1), nk_reg};
            end
            S_SP_MN:
            begin
                meta_we    = 1'b1;
                meta_waddr = biu_reg[DIR_W-1:0];
                meta_wdata = {ld_reg + LD_W'(1), nn_reg};
                cnt_next   = '0;
            end
            S_SP_DRD:
            begin
                if (cnt_reg == dir_span)
                begin
                    biu_next = biu_reg + CNT_W'(1);
                end
            end
            S_SP_DWR:
            begin
                // entries of the old bucket with the split bit set move to the new one
                dir_we   = (dir_q == b_reg) && cnt_reg[ld_reg];
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    res_next.status       = stat_reg;
                    res_next.bucket_index = where_reg;
                    res_next.depth_now    = gd_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gd_reg <= GD_W'(MAX_DEPTH))
        else $error("global depth beyond limit");

    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        gd_reg != $past(gd_reg) |-> gd_reg == $past(gd_reg) + GD_W'(1))
        else $error("global depth jumped");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DIR_RD || state_reg == S_DONE)
        else $error("bad state after accept");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.status != STAT_OK |-> res_reg.bucket_index == '0)
        else $error("index set on failed command");

endmodule

// ===== hw/rtl/extendible_hash_table_top.sv =====
// top level: stream ports, configuration registers and the hash table core
//
// extendible hash table with an identity hash: the directory index of a key is
// its low global-depth bits, each bucket holds up to bucket_capacity keys (1..4,
// register at byte address 0, reset 3). one command word in, one result word
// out. the block works on one command at a time under a sequencer, with
// directory, bucket and slot memories each giving one registered read and one
// write per cycle, and each command is carried out as a walk over them:
// search scans the bucket slot by slot, delete then shifts each following key
// down, and a plain insert writes one slot. a full bucket is split by moving
// its keys and rewriting the directory, after which the lookup is retried; the
// directory doubles before a split when the bucket depth equals global depth.
// a command can accept while the previous result still waits in the output
// register. no clearing pass after reset is needed
module extendible_hash_table_top
    import ehash_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // command word
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((KEY_WIDTH+7)/8)*8-1:0]     s_tdata,   // key
    input  logic [1:0]                         s_tuser,   // command
    // result word
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // bucket_index, depth_now
    output logic [1:0]                         m_tuser,   // status
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int REG_CAPACITY = 0;

    logic [CAP_W-1:0] cap_reg;
    result_t          res;

    // bucket_capacity register, decoded on the word index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == 1'(REG_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'(REG_CAPACITY)) ? {{(32-CAP_W){1'b0}}, cap_reg} : '0;

    ehash_core #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .capacity   (cap_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser),
        .in_key     (s_tdata[KEY_WIDTH-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    // pack result word, zero filled to two bytes
    assign m_tdata = {{(16-DIR_W-GD_W){1'b0}}, res.depth_now, res.bucket_index};
    assign m_tuser = res.status;

endmodule
